// File: rtl/core/rsv_pkg.sv
`timescale 1ns / 1ps

package rsv_pkg;

   // Sequence number width and the derived modulus.
   localparam int SEQ_BITS = 16;
   localparam logic [SEQ_BITS:0] SEQ_MOD = {1'b1, {SEQ_BITS{1'b0}}};

   // Depth of the word queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SEQUENTIAL = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_MISORDER   = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_DROPOUT    = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_US_PER_TICK    = 8'd3;

   localparam logic [7:0]  MIN_SEQUENTIAL_RESET = 8'd2;
   localparam logic [15:0] MAX_MISORDER_RESET   = 16'd100;
   localparam logic [15:0] MAX_DROPOUT_RESET    = 16'd3000;
   localparam logic [31:0] US_PER_TICK_RESET    = 32'd8192000;

   typedef logic [SEQ_BITS-1:0] seq_type;

   typedef enum logic [2:0] {
      VERDICT_VALID     = 3'd0,
      VERDICT_PROBATION = 3'd1,
      VERDICT_DUPLICATE = 3'd2,
      VERDICT_JUMPED    = 3'd3,
      VERDICT_INVALID   = 3'd4,
      VERDICT_QUERY     = 3'd5
   } verdict_type;

   typedef struct packed {
      logic [7:0]  min_sequential;
      logic [15:0] max_misorder;
      logic [15:0] max_dropout;
      logic [31:0] us_per_tick;
   } cfg_type;

   // One word as it travels from the front to the back.
   typedef struct packed {
      logic        query;
      seq_type     seq;
      logic        stamp_zero;
      logic [48:0] prod_hi;
      logic [31:0] arrival;
   } item_type;

endpackage

// File: rtl/core/rsv_front.sv
`timescale 1ns / 1ps

module rsv_front import rsv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [15:0] req_seq_num,
   input  logic [31:0] req_media_stamp,
   input  logic [31:0] req_arrival_us,
   input  logic [31:0] us_per_tick,
   output logic        push_valid,
   input  logic        push_ready,
   output item_type    push_item
);

   logic        hold_valid_ff, hold_valid_in;
   logic        kind_ff;
   seq_type     seq_ff;
   logic [31:0] stamp_ff;
   logic [31:0] arrival_ff;
   logic [63:0] product;
   logic        accept;

   // The holding register stalls the requester only while the queue is full.
   assign req_stall = hold_valid_ff && !push_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      if (accept) begin
         kind_ff    <= req_kind;
         seq_ff     <= req_seq_num[SEQ_BITS-1:0];
         stamp_ff   <= req_media_stamp;
         arrival_ff <= req_arrival_us;
      end
   end

   // Scale the media stamp to microseconds; the queue register follows.
   assign product = 64'(stamp_ff) * 64'(us_per_tick);

   assign push_valid           = hold_valid_ff;
   assign push_item.query      = kind_ff;
   assign push_item.seq        = seq_ff;
   assign push_item.stamp_zero = (stamp_ff == 32'd0);
   assign push_item.prod_hi    = product[63:15];
   assign push_item.arrival    = arrival_ff;

endmodule

// File: rtl/core/rsv_queue.sv
`timescale 1ns / 1ps

module rsv_queue import rsv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   item_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/rsv_back.sv
`timescale 1ns / 1ps

module rsv_back import rsv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  item_type    pop_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_verdict,
   output logic [31:0] rsp_jitter_q4,
   output logic [7:0]  rsp_loss_fraction,
   output logic [31:0] rsp_ext_highest_seq,
   output logic [31:0] rsp_received_count
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_J_DIFF,
      ST_J_D,
      ST_J_MAG,
      ST_J_ACC,
      ST_Q_INT,
      ST_Q_CHK,
      ST_Q_DIV,
      ST_DONE
   } state_type;

   state_type   state_ff, state_in;

   // Current word.
   logic        query_ff, query_in;
   seq_type     seq_ff, seq_in;
   logic        stamp_zero_ff, stamp_zero_in;
   logic [47:0] stamp_us_ff, stamp_us_in;
   logic [31:0] arrival_ff, arrival_in;

   // Source state.
   seq_type     highest_ff, highest_in;
   seq_type     base_ff, base_in;
   logic [SEQ_BITS:0] bad_ff, bad_in;
   logic [15:0] cycles_ff, cycles_in;
   logic [7:0]  probation_ff, probation_in;
   logic        not_started_ff, not_started_in;
   logic [31:0] rx_count_ff, rx_count_in;
   logic [31:0] rx_prior_ff, rx_prior_in;
   logic [31:0] exp_prior_ff, exp_prior_in;
   logic [31:0] prev_arrival_ff, prev_arrival_in;
   logic [47:0] prev_stamp_ff, prev_stamp_in;
   logic        prev_valid_ff, prev_valid_in;
   logic [31:0] jitter_ff, jitter_in;

   // Work registers of the jitter and loss sequences.
   logic [31:0] adelta_ff, adelta_in;
   logic [48:0] sdiff_ff, sdiff_in;
   logic [50:0] d_ff, d_in;
   logic [49:0] mag_ff, mag_in;
   logic [31:0] expected_ff, expected_in;
   logic [31:0] rx_int_ff, rx_int_in;
   logic [31:0] exp_int_ff, exp_int_in;
   logic [32:0] rem_ff, rem_in;
   logic [8:0]  quot_ff, quot_in;
   logic [3:0]  bit_cnt_ff, bit_cnt_in;
   verdict_type verdict_ff, verdict_in;
   logic [7:0]  loss_ff, loss_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_verdict_ff;
   logic [31:0] rsp_jitter_ff, rsp_ext_ff, rsp_rx_ff;
   logic [7:0]  rsp_loss_ff;
   logic        load_rsp;

   // Helpers.
   logic [31:0]     ext_highest;
   seq_type         udelta;
   logic [SEQ_BITS:0] jump_sum;
   logic [49:0]     stamp_round;
   logic [53:0]     acc_sum;
   logic [53:0]     acc_shift;
   logic [32:0]     div_ext;
   logic            div_ge;
   logic [32:0]     rem_next;
   logic [7:0]      prob_dec;

   assign ext_highest = 32'({cycles_ff, highest_ff});
   assign udelta      = seq_ff - highest_ff;
   assign jump_sum    = {1'b0, udelta} + (SEQ_BITS + 1)'(cfg.max_misorder);
   assign stamp_round = 50'(pop_item.prod_hi) + 50'd1;
   assign acc_sum     = 54'(jitter_ff) * 54'd15 + {mag_ff, 4'b0000} + 54'd8;
   assign acc_shift   = acc_sum >> 4;
   assign div_ext     = {1'b0, exp_int_ff};
   assign div_ge      = (rem_ff >= div_ext);
   assign rem_next    = div_ge ? rem_ff - div_ext : rem_ff;
   assign prob_dec    = probation_ff - 8'd1;

   assign pop_ready = (state_ff == ST_IDLE);
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in        = state_ff;
      query_in        = query_ff;
      seq_in          = seq_ff;
      stamp_zero_in   = stamp_zero_ff;
      stamp_us_in     = stamp_us_ff;
      arrival_in      = arrival_ff;
      highest_in      = highest_ff;
      base_in         = base_ff;
      bad_in          = bad_ff;
      cycles_in       = cycles_ff;
      probation_in    = probation_ff;
      not_started_in  = not_started_ff;
      rx_count_in     = rx_count_ff;
      rx_prior_in     = rx_prior_ff;
      exp_prior_in    = exp_prior_ff;
      prev_arrival_in = prev_arrival_ff;
      prev_stamp_in   = prev_stamp_ff;
      prev_valid_in   = prev_valid_ff;
      jitter_in       = jitter_ff;
      adelta_in       = adelta_ff;
      sdiff_in        = sdiff_ff;
      d_in            = d_ff;
      mag_in          = mag_ff;
      expected_in     = expected_ff;
      rx_int_in       = rx_int_ff;
      exp_int_in      = exp_int_ff;
      rem_in          = rem_ff;
      quot_in         = quot_ff;
      bit_cnt_in      = bit_cnt_ff;
      verdict_in      = verdict_ff;
      loss_in         = loss_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      case (state_ff)
         // Take the next word from the queue and round its stamp.
         ST_IDLE: begin
            if (pop_valid) begin
               query_in      = pop_item.query;
               seq_in        = pop_item.seq;
               stamp_zero_in = pop_item.stamp_zero;
               stamp_us_in   = stamp_round[48:1];
               arrival_in    = pop_item.arrival;
               state_in      = ST_CLASSIFY;
            end
         end

         // Sequence classification, or the start of a loss query.
         ST_CLASSIFY: begin
            loss_in  = 8'd0;
            state_in = ST_DONE;
            if (query_ff) begin
               verdict_in = VERDICT_QUERY;
               if (!not_started_ff) begin
                  expected_in = ext_highest - 32'(base_ff) + 32'd1;
                  rx_int_in   = rx_count_ff - rx_prior_ff;
                  state_in    = ST_Q_INT;
               end
            end else if (probation_ff != 8'd0) begin
               verdict_in = VERDICT_PROBATION;
               highest_in = seq_ff;
               if (seq_ff == highest_ff + 1'b1) begin
                  probation_in = prob_dec;
                  if (prob_dec == 8'd0) begin
                     base_in         = seq_ff;
                     bad_in          = SEQ_MOD + 1'b1;
                     cycles_in       = 16'd0;
                     rx_count_in     = 32'd1;
                     rx_prior_in     = 32'd0;
                     exp_prior_in    = 32'd0;
                     not_started_in  = 1'b0;
                     prev_arrival_in = arrival_ff;
                     prev_stamp_in   = stamp_us_ff;
                     prev_valid_in   = 1'b1;
                     jitter_in       = 32'd0;
                     verdict_in      = VERDICT_VALID;
                  end
               end else begin
                  probation_in = cfg.min_sequential;
               end
            end else if (udelta == '0) begin
               verdict_in = VERDICT_DUPLICATE;
            end else if ((udelta < cfg.max_dropout[SEQ_BITS-1:0]) ||
                         (jump_sum > SEQ_MOD)) begin
               // In order, or a small reorder: count the packet.
               if (udelta < cfg.max_dropout[SEQ_BITS-1:0]) begin
                  if (seq_ff < highest_ff) begin
                     cycles_in = cycles_ff + 16'd1;
                  end
                  highest_in = seq_ff;
               end
               rx_count_in = rx_count_ff + 32'd1;
               verdict_in  = VERDICT_VALID;
               if (!stamp_zero_ff) begin
                  state_in = ST_J_DIFF;
               end
            end else if ({1'b0, seq_ff} == bad_ff) begin
               // Second packet after a jump: resynchronize.
               base_in      = seq_ff;
               highest_in   = seq_ff;
               bad_in       = SEQ_MOD + 1'b1;
               cycles_in    = 16'd0;
               rx_count_in  = 32'd1;
               rx_prior_in  = 32'd0;
               exp_prior_in = 32'd0;
               verdict_in   = VERDICT_JUMPED;
            end else begin
               bad_in     = {1'b0, seq_ff + 1'b1};
               verdict_in = VERDICT_INVALID;
            end
         end

         // Arrival and transit deltas, and the new reference point.
         ST_J_DIFF: begin
            adelta_in       = arrival_ff - prev_arrival_ff;
            sdiff_in        = {1'b0, stamp_us_ff} - {1'b0, prev_stamp_ff};
            prev_arrival_in = arrival_ff;
            prev_stamp_in   = stamp_us_ff;
            prev_valid_in   = 1'b1;
            state_in        = prev_valid_ff ? ST_J_D : ST_DONE;
         end

         ST_J_D: begin
            d_in     = 51'(adelta_ff) - {{2{sdiff_ff[48]}}, sdiff_ff};
            state_in = ST_J_MAG;
         end

         ST_J_MAG: begin
            mag_in   = d_ff[50] ? 50'(-d_ff) : d_ff[49:0];
            state_in = ST_J_ACC;
         end

         // Smoothing step of the jitter estimate, saturated.
         ST_J_ACC: begin
            jitter_in = (acc_shift > 54'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc_shift[31:0];
            state_in  = ST_DONE;
         end

         ST_Q_INT: begin
            exp_int_in   = expected_ff - exp_prior_ff;
            exp_prior_in = expected_ff;
            rx_prior_in  = rx_count_ff;
            state_in     = ST_Q_CHK;
         end

         ST_Q_CHK: begin
            if ((exp_int_ff == 32'd0) || (rx_int_ff >= exp_int_ff)) begin
               state_in = ST_DONE;
            end else begin
               rem_in     = {1'b0, exp_int_ff - rx_int_ff};
               quot_in    = 9'd0;
               bit_cnt_in = 4'd8;
               state_in   = ST_Q_DIV;
            end
         end

         // Restoring division, one quotient bit a cycle.
         ST_Q_DIV: begin
            quot_in    = {quot_ff[7:0], div_ge};
            rem_in     = {rem_next[31:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 4'd1;
            if (bit_cnt_ff == 4'd0) begin
               loss_in  = quot_ff[7] ? 8'hFF : {quot_ff[6:0], div_ge};
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         highest_ff      <= '1;
         base_ff         <= '0;
         bad_ff          <= SEQ_MOD + 1'b1;
         cycles_ff       <= 16'd0;
         probation_ff    <= MIN_SEQUENTIAL_RESET;
         not_started_ff  <= 1'b1;
         rx_count_ff     <= 32'd0;
         rx_prior_ff     <= 32'd0;
         exp_prior_ff    <= 32'd0;
         prev_arrival_ff <= 32'd0;
         prev_stamp_ff   <= 48'd0;
         prev_valid_ff   <= 1'b0;
         jitter_ff       <= 32'd0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         highest_ff      <= highest_in;
         base_ff         <= base_in;
         bad_ff          <= bad_in;
         cycles_ff       <= cycles_in;
         probation_ff    <= probation_in;
         not_started_ff  <= not_started_in;
         rx_count_ff     <= rx_count_in;
         rx_prior_ff     <= rx_prior_in;
         exp_prior_ff    <= exp_prior_in;
         prev_arrival_ff <= prev_arrival_in;
         prev_stamp_ff   <= prev_stamp_in;
         prev_valid_ff   <= prev_valid_in;
         jitter_ff       <= jitter_in;
      end
      query_ff      <= query_in;
      seq_ff        <= seq_in;
      stamp_zero_ff <= stamp_zero_in;
      stamp_us_ff   <= stamp_us_in;
      arrival_ff    <= arrival_in;
      adelta_ff     <= adelta_in;
      sdiff_ff      <= sdiff_in;
      d_ff          <= d_in;
      mag_ff        <= mag_in;
      expected_ff   <= expected_in;
      rx_int_ff     <= rx_int_in;
      exp_int_ff    <= exp_int_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      bit_cnt_ff    <= bit_cnt_in;
      verdict_ff    <= verdict_in;
      loss_ff       <= loss_in;
      if (load_rsp) begin
         rsp_verdict_ff <= verdict_ff;
         rsp_jitter_ff  <= jitter_ff;
         rsp_loss_ff    <= loss_ff;
         rsp_ext_ff     <= ext_highest;
         rsp_rx_ff      <= rx_count_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = rsp_verdict_ff;
   assign rsp_jitter_q4       = rsp_jitter_ff;
   assign rsp_loss_fraction   = rsp_loss_ff;
   assign rsp_ext_highest_seq = rsp_ext_ff;
   assign rsp_received_count  = rsp_rx_ff;

`ifndef SYNTHESIS
   // Only a query answer carries a loss fraction.
   a_loss_only_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_verdict_ff != VERDICT_QUERY) |-> rsp_loss_ff == 8'd0)
      else $error("loss fraction set on a packet result");

   // A started source has left probation.
   a_started_no_probation: assert property (@(posedge clock) disable iff (reset)
      !not_started_ff |-> probation_ff == 8'd0)
      else $error("started source still on probation");

   // The division remainder stays below twice the divisor.
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_Q_DIV |-> rem_ff < {div_ext[31:0], 1'b0})
      else $error("division remainder out of range");

   // No word is taken from the queue while a result waits to be loaded.
   a_no_pop_in_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && !load_rsp |=> state_ff == ST_DONE)
      else $error("sequencer left the result state without loading");
`endif

endmodule

// File: rtl/core/rtp_sequence_validator_core.sv
`timescale 1ns / 1ps

// Receiver-side RTP source checker: each packet word is classified by its
// sequence number (valid, probation, duplicate, resynchronized, invalid) and
// a counted one with a nonzero stamp updates the interarrival jitter; a query
// word returns the 8-bit loss fraction since the previous query. The front
// stage takes a word every cycle while the two-entry queue has room and
// scales the media stamp with one 32 by 32 multiply. The back sequencer works
// on one word at a time and pops the next only after loading the result
// register. A counted packet with a nonzero stamp takes its arrival and
// transit deltas and a new reference point and, with an earlier reference,
// their difference, its magnitude and the jitter update. A query on a started
// source takes the interval counts and, when there is loss to report, runs
// the bit-serial loss division. A stalled result holds the sequencer until it
// is taken. Configuration must be written only while the block is idle; the
// block itself does not enforce this.

module rtp_sequence_validator_core import rsv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [15:0] req_seq_num,
   input  logic [31:0] req_media_stamp,
   input  logic [31:0] req_arrival_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_verdict,
   output logic [31:0] rsp_jitter_q4,
   output logic [7:0]  rsp_loss_fraction,
   output logic [31:0] rsp_ext_highest_seq,
   output logic [31:0] rsp_received_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid, push_ready, pop_valid, pop_ready;
   item_type push_item, pop_item;

   // Register bank; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MIN_SEQUENTIAL: cfg_in.min_sequential = csr_wdata[7:0];
            CSR_MAX_MISORDER:   cfg_in.max_misorder   = csr_wdata[15:0];
            CSR_MAX_DROPOUT:    cfg_in.max_dropout    = csr_wdata[15:0];
            CSR_US_PER_TICK:    cfg_in.us_per_tick    = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_sequential <= MIN_SEQUENTIAL_RESET;
         cfg_ff.max_misorder   <= MAX_MISORDER_RESET;
         cfg_ff.max_dropout    <= MAX_DROPOUT_RESET;
         cfg_ff.us_per_tick    <= US_PER_TICK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rsv_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_seq_num     (req_seq_num),
      .req_media_stamp (req_media_stamp),
      .req_arrival_us  (req_arrival_us),
      .us_per_tick     (cfg_ff.us_per_tick),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_item       (push_item)
   );

   rsv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   rsv_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_item            (pop_item),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_verdict         (rsp_verdict),
      .rsp_jitter_q4       (rsp_jitter_q4),
      .rsp_loss_fraction   (rsp_loss_fraction),
      .rsp_ext_highest_seq (rsp_ext_highest_seq),
      .rsp_received_count  (rsp_received_count)
   );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import rsv_pkg::*;

   // An index that maps to no register; writes to it must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 8'd9;

   typedef struct {
      verdict_type verdict;
      logic [31:0] jitter;
      logic [7:0]  loss;
      logic [31:0] ext_seq;
      logic [31:0] rx;
   } report_type;

   // Tracks the source state of the block and holds the reports it owes.
   class rtp_source_tracker;
      logic [7:0]  min_seq;
      logic [15:0] misorder;
      logic [15:0] dropout;
      logic [31:0] us_tick;
      logic [15:0] top_seq;
      logic [15:0] base_seq;
      logic [16:0] bad_seq;
      logic [15:0] cycles;
      logic [7:0]  probation;
      logic        fresh;
      logic        ref_ok;
      logic [31:0] rx;
      logic [31:0] rx_prev;
      logic [31:0] exp_prev;
      logic [31:0] last_arr;
      logic [47:0] last_us;
      logic [31:0] jitter;
      int          errors;
      report_type  pending_reports[$];

      function new();
         min_seq = MIN_SEQUENTIAL_RESET;
         misorder = MAX_MISORDER_RESET;
         dropout = MAX_DROPOUT_RESET;
         us_tick = US_PER_TICK_RESET;
         restart_source(16'd0);
         top_seq = 16'hFFFF;
         probation = min_seq;
         fresh = 1'b1;
         ref_ok = 1'b0;
         last_arr = '0;
         last_us = '0;
         jitter = '0;
         errors = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] value);
         case (idx)
            CSR_MIN_SEQUENTIAL: min_seq = value[7:0];
            CSR_MAX_MISORDER:   misorder = value[15:0];
            CSR_MAX_DROPOUT:    dropout = value[15:0];
            CSR_US_PER_TICK:    us_tick = value;
            default: ;
         endcase
      endfunction

      function void restart_source(logic [15:0] seq);
         base_seq = seq;
         top_seq = seq;
         bad_seq = 17'h10001;
         cycles = '0;
         rx = '0;
         rx_prev = '0;
         exp_prev = '0;
      endfunction

      // Media stamp scaled to microseconds, rounded half up.
      function logic [47:0] stamp_us(logic [31:0] stamp);
         logic [63:0] p;
         p = 64'(stamp) * 64'(us_tick) + 64'h8000;
         return p[63:16];
      endfunction

      function void update_jitter(logic [31:0] now, logic [47:0] su);
         longint d;
         logic [63:0] mag;
         logic [63:0] acc;
         if (ref_ok) begin
            d = longint'({32'b0, now - last_arr}) - (longint'({16'b0, su})
                - longint'({16'b0, last_us}));
            mag = d < 0 ? 64'(-d) : 64'(d);
            acc = (64'(jitter) * 15 + (mag << 4) + 64'd8) >> 4;
            jitter = acc > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : acc[31:0];
         end
         last_arr = now;
         last_us = su;
         ref_ok = 1'b1;
      endfunction

      function verdict_type classify(logic [15:0] seq, logic [31:0] stamp, logic [31:0] now);
         logic [15:0] udelta;
         udelta = seq - top_seq;
         if (probation != 0) begin
            if (seq == top_seq + 16'd1) begin
               probation = probation - 8'd1;
               top_seq = seq;
               if (probation == 0) begin
                  restart_source(seq);
                  rx = 32'd1;
                  fresh = 1'b0;
                  last_arr = now;
                  last_us = stamp_us(stamp);
                  ref_ok = 1'b1;
                  jitter = '0;
                  return VERDICT_VALID;
               end
            end else begin
               top_seq = seq;
               probation = min_seq;
            end
            return VERDICT_PROBATION;
         end
         if (udelta == 0)
            return VERDICT_DUPLICATE;
         if (udelta < dropout) begin
            if (seq < top_seq)
               cycles = cycles + 16'd1;
            top_seq = seq;
         end else if (32'(udelta) + 32'(misorder) <= 32'h10000) begin
            if ({1'b0, seq} == bad_seq) begin
               restart_source(seq);
               rx = 32'd1;
               return VERDICT_JUMPED;
            end
            bad_seq = {1'b0, seq + 16'd1};
            return VERDICT_INVALID;
         end
         // Reordered inside the window, or in order: counted.
         rx = rx + 32'd1;
         if (stamp != 0)
            update_jitter(now, stamp_us(stamp));
         return VERDICT_VALID;
      endfunction

      function logic [7:0] loss_fraction();
         logic [31:0] expected;
         logic [31:0] exp_int;
         logic [31:0] rx_int;
         logic [63:0] frac;
         if (fresh)
            return 8'd0;
         expected = {cycles, top_seq} - {16'b0, base_seq} + 32'd1;
         exp_int = expected - exp_prev;
         rx_int = rx - rx_prev;
         exp_prev = expected;
         rx_prev = rx;
         if (exp_int == 0 || rx_int >= exp_int)
            return 8'd0;
         frac = (64'(exp_int - rx_int) << 8) / 64'(exp_int);
         return frac > 64'd255 ? 8'd255 : frac[7:0];
      endfunction

      // Notes an accepted word and queues the report it must produce.
      function void accept_word(logic kind, logic [15:0] seq, logic [31:0] stamp,
                                logic [31:0] now);
         report_type r;
         r.loss = 8'd0;
         if (kind) begin
            r.loss = loss_fraction();
            r.verdict = VERDICT_QUERY;
         end else begin
            r.verdict = classify(seq, stamp, now);
         end
         r.jitter = jitter;
         r.ext_seq = {cycles, top_seq};
         r.rx = rx;
         pending_reports.push_back(r);
      endfunction

      // Compares one accepted report with the oldest one owed.
      function void check_word(report_type got);
         report_type want;
         if (pending_reports.size() == 0) begin
            $error("report with none outstanding: verdict %0d", got.verdict);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         if (got.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
            errors++;
         end
         if (got.jitter !== want.jitter) begin
            $error("jitter_q4: expected %0d, got %0d", want.jitter, got.jitter);
            errors++;
         end
         if (got.loss !== want.loss) begin
            $error("loss_fraction: expected %0d, got %0d", want.loss, got.loss);
            errors++;
         end
         if (got.ext_seq !== want.ext_seq) begin
            $error("ext_highest_seq: expected %0d, got %0d", want.ext_seq, got.ext_seq);
            errors++;
         end
         if (got.rx !== want.rx) begin
            $error("received_count: expected %0d, got %0d", want.rx, got.rx);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [15:0] req_seq_num = '0;
   logic [31:0] req_media_stamp = '0;
   logic [31:0] req_arrival_us = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_verdict;
   logic [31:0] rsp_jitter_q4;
   logic [7:0]  rsp_loss_fraction;
   logic [31:0] rsp_ext_highest_seq;
   logic [31:0] rsp_received_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   rtp_source_tracker tracker = new();

   // Random idling on both sides, and long hold-offs asked by the stimulus.
   bit          idle_on = 1'b1;
   int          hold_asked = 0;
   int          hold_served = 0;
   int          hold_left = 0;

   // Stream position used by the random sequences.
   logic [15:0] cur_seq;
   logic [31:0] cur_stamp = 32'd1000;
   logic [31:0] cur_arr = 32'd5000;

   rtp_sequence_validator_core uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: check each accepted word, then pick the next stall.
   always @(posedge clock) begin
      report_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.verdict = verdict_type'(rsp_verdict);
            got.jitter = rsp_jitter_q4;
            got.loss = rsp_loss_fraction;
            got.ext_seq = rsp_ext_highest_seq;
            got.rx = rsp_received_count;
            tracker.check_word(got);
         end
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < 13);
         end
      end
   end

   // Offers one word, idling first at random, and waits until it is taken.
   task automatic send_word(logic kind, logic [15:0] seq, logic [31:0] stamp,
                            logic [31:0] now);
      while (idle_on && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_seq_num <= seq;
      req_media_stamp <= stamp;
      req_arrival_us <= now;
      do @(posedge clock); while (req_stall);
      tracker.accept_word(kind, seq, stamp, now);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending_reports.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.set_register(idx, value);
   endtask

   task automatic set_config(logic [7:0] min_seq, logic [15:0] misorder,
                             logic [15:0] dropout, logic [31:0] us_tick);
      drain();
      write_reg(CSR_MIN_SEQUENTIAL, {24'($urandom), min_seq});
      write_reg(CSR_MAX_MISORDER, {16'($urandom), misorder});
      write_reg(CSR_MAX_DROPOUT, {16'($urandom), dropout});
      write_reg(CSR_US_PER_TICK, us_tick);
      write_reg(CSR_UNUSED, $urandom);
   endtask

   // Mostly a well-formed stream with gaps, reorders, jumps and queries.
   task automatic play_stream(int count, int us_step);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         cur_stamp = cur_stamp + 32'd160;
         cur_arr = cur_arr + 32'(160 * us_step) + $urandom_range(400);
         if (r < 55) begin
            cur_seq++;
            send_word(1'b0, cur_seq, cur_stamp, cur_arr);
         end else if (r < 63) begin
            cur_seq = cur_seq + 16'($urandom_range(2, 40));
            send_word(1'b0, cur_seq, cur_stamp, cur_arr);
         end else if (r < 68) begin
            send_word(1'b0, cur_seq, cur_stamp, cur_arr);
         end else if (r < 73) begin
            send_word(1'b0, cur_seq - 16'($urandom_range(1, 120)), cur_stamp, cur_arr);
         end else if (r < 78) begin
            // A jump followed by its successor resynchronizes the source.
            cur_seq = $urandom_range(1) ? 16'hFFC0 + 16'($urandom_range(63))
                                        : 16'($urandom);
            send_word(1'b0, cur_seq, cur_stamp, cur_arr);
            cur_seq++;
            send_word(1'b0, cur_seq, cur_stamp + 32'd1, cur_arr + 32'd7);
         end else if (r < 86) begin
            send_word(1'b1, 16'($urandom), $urandom, $urandom);
         end else if (r < 93) begin
            send_word(1'($urandom_range(1)), 16'($urandom), $urandom, $urandom);
         end else begin
            cur_seq++;
            send_word(1'b0, cur_seq, 32'd0, cur_arr);
         end
      end
   endtask

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset settings.
      send_word(1'b1, 16'd0, 32'd0, 32'd0);
      send_word(1'b0, 16'hFFFF, 32'd0, 32'd0);
      send_word(1'b0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(1'b0, 16'd1, 32'd100, 32'd12500);
      send_word(1'b0, 16'd1, 32'd100, 32'd12500);
      send_word(1'b0, 16'd2, 32'd0, 32'd13000);
      send_word(1'b0, 16'd3, 32'd300, 32'd40000);
      send_word(1'b0, 16'd10, 32'd310, 32'd41000);
      send_word(1'b0, 16'd5, 32'd305, 32'd40500);
      send_word(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(1'b0, 16'd40000, 32'd1, 32'd1);
      send_word(1'b0, 16'd40001, 32'd2, 32'd2);
      send_word(1'b0, 16'd40002, 32'hFFFF_FFFF, 32'd0);
      send_word(1'b0, 16'd40003, 32'd1, 32'hFFFF_FFFF);
      send_word(1'b0, 16'd39990, 32'd5, 32'd100);
      send_word(1'b0, 16'd42990, 32'd6, 32'd200);
      send_word(1'b0, 16'd42989, 32'd7, 32'd300);
      send_word(1'b1, 16'd0, 32'd0, 32'd0);
      send_word(1'b1, 16'd0, 32'd0, 32'd0);
      cur_seq = 16'd42990;

      // Reset settings, with a long stretch of no idling at all.
      play_stream(100, 125);
      idle_on = 1'b0;
      play_stream(100, 125);
      idle_on = 1'b1;

      // Widest windows and the largest scale.
      set_config(8'd255, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      play_stream(150, 65536);

      // No reordering, no in-order step, zero scale.
      set_config(8'd0, 16'd0, 16'd1, 32'd0);
      play_stream(150, 0);

      // Middle settings, with a receiver hold-off and a sender pause.
      set_config(8'd3, 16'd50, 16'd200, 32'h0001_0000);
      play_stream(80, 1);
      hold_asked++;
      idle_on = 1'b0;
      play_stream(40, 1);
      idle_on = 1'b1;
      drain();
      play_stream(150, 1);

      drain();
      if (tracker.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
